### src/four_voice_sample_playback_mixer_macros.svh
// Assertion macros shared by the mixer RTL
`ifndef FOUR_VOICE_SAMPLE_PLAYBACK_MIXER_MACROS_SVH
`define FOUR_VOICE_SAMPLE_PLAYBACK_MIXER_MACROS_SVH

// Same-cycle implication under the synchronous reset
`define FVM_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication under the synchronous reset
`define FVM_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### src/fvm_pkg.sv
// ----------------------------------------------------------------------------
// fvm_pkg
// Shared constants and types of the four-voice sample playback mixer.
// ----------------------------------------------------------------------------
package fvm_pkg;

  localparam int FRAC_BITS = 12;
  localparam int SAMPLE_ADDR_BITS = 16;
  localparam int VOICES = 4;

  localparam int LEN_W = 17;
  localparam int SPAN_W = LEN_W + FRAC_BITS;
  // phase holds a span plus one step of up to 32 bits
  localparam int PH_W = ((SPAN_W > 32) ? SPAN_W : 32) + 1;
  localparam int DVS_W = PH_W - 1;
  localparam int CNT_W = $clog2(PH_W + 1);
  localparam int ACC_W = 20;
  localparam int MIX_W = 15;

  localparam logic [6:0] MAX_VOL = 7'd64;
  localparam logic [3:0] OS_RESET = 4'd1;
  localparam logic [31:0] NUM_RESET = 32'd329435;

  typedef enum logic [2:0] {
    REQ_WRITE  = 3'd0,
    REQ_NOTE   = 3'd1,
    REQ_PERIOD = 3'd2,
    REQ_VOLUME = 3'd3,
    REQ_TICK   = 3'd4
  } req_t;

  typedef enum logic [1:0] {
    MODE_SILENT = 2'd0,
    MODE_BODY   = 2'd1,
    MODE_LOOP   = 2'd2
  } mode_t;

  typedef enum logic {
    CFG_OVERSAMPLE = 1'b0,
    CFG_NUMERATOR  = 1'b1
  } cfg_idx_t;

endpackage

### src/four_voice_sample_playback_mixer.sv
// ----------------------------------------------------------------------------
// four_voice_sample_playback_mixer
// Four-voice wavetable player with an 8-bit sample memory and stereo mix.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready) carries requests: sample byte write,
//   note start, period change, volume set and tick. Only a tick produces a
//   result, one stereo frame on out_valid/out_ready.
//   Sample writes and volume sets finish without leaving idle. Note and
//   period requests run step = numerator / period on the shared restoring
//   divider; when period is 0 the step is set to zero without a division.
//   A tick walks the voices one sub-step at a time through the same unit:
//   each sub-step is a sample memory read, then multiply and accumulate; a
//   body-to-loop change adds a pass of its own, and a looping phase that
//   leaves the loop is reduced modulo the loop length on the divider.
//   The tick ends with two divisions by oversample, one per side.
//   in_ready is high only while the sequencer is idle. A finished frame sits
//   in the output register; the block keeps taking requests, and a later
//   tick waits at its end until the frame ahead has been transferred.
//   Reset silences all voices and clears steps, volumes and note fields;
//   sample memory is not cleared and must be written before it is played.
// ----------------------------------------------------------------------------
`include "four_voice_sample_playback_mixer_macros.svh"

module four_voice_sample_playback_mixer (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_we,
  input  logic               cfg_index,
  input  logic [31:0]        cfg_wdata,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [2:0]         in_req_type,
  input  logic [1:0]         in_voice,
  input  logic [15:0]        in_address,
  input  logic signed [7:0]  in_sample_byte,
  input  logic [11:0]        in_period,
  input  logic [16:0]        in_body_length,
  input  logic [15:0]        in_loop_address,
  input  logic [16:0]        in_loop_length,
  input  logic [6:0]         in_volume_request,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [14:0] out_left_mix,
  output logic signed [14:0] out_right_mix
);

  localparam int AW = fvm_pkg::SAMPLE_ADDR_BITS;
  localparam int PW = fvm_pkg::PH_W;
  localparam int DW = fvm_pkg::DVS_W;
  localparam int CW = fvm_pkg::CNT_W;
  localparam int XW = fvm_pkg::ACC_W;
  localparam int FB = fvm_pkg::FRAC_BITS;
  localparam int SW = fvm_pkg::SPAN_W;
  localparam int NV = fvm_pkg::VOICES;

  typedef enum logic [2:0] {
    S_IDLE, S_SUB, S_MAC, S_MIX, S_DIV, S_OUT
  } state_t;

  typedef enum logic [1:0] {
    P_STEP, P_MOD, P_LEFT, P_RIGHT
  } purpose_t;

  // configuration
  logic [3:0]  os_cfg_r;
  logic [31:0] num_cfg_r;
  logic [3:0]  os_eff;

  // voice state
  fvm_pkg::mode_t mode_r [NV];
  logic [PW-1:0]  phase_r [NV];
  logic [31:0]    step_r [NV];
  logic [6:0]     vol_r [NV];
  logic [15:0]    bstart_r [NV];
  logic [16:0]    blen_r [NV];
  logic [15:0]    lstart_r [NV];
  logic [16:0]    llen_r [NV];

  // sequencer
  state_t            state_r;
  purpose_t          purp_r;
  logic [1:0]        v_r;
  logic [3:0]        s_r;
  logic signed [XW-1:0] accl_r, accr_r;
  logic [PW-1:0]     quo_r;
  logic [DW-1:0]     rem_r;
  logic [DW-1:0]     dvs_r;
  logic [CW-1:0]     cnt_r;
  logic              neg_r;
  logic signed [14:0] left_r, right_r;
  logic signed [14:0] out_left_r, out_right_r;
  logic              out_valid_r;

  // sample memory
  logic [7:0]        mem [2**AW];
  logic signed [7:0] rd_r;

  logic in_xfer;
  fvm_pkg::req_t req;
  assign in_xfer  = in_valid && in_ready;
  assign in_ready = (state_r == S_IDLE);
  assign req      = fvm_pkg::req_t'(in_req_type);
  assign os_eff   = (os_cfg_r == 4'd0) ? 4'd1 : os_cfg_r;

  // current voice views
  logic [PW-1:0] cur_ph;
  logic [PW-1:0] cur_blen, cur_llen;
  logic [AW-1:0] rd_addr;
  logic          mem_re;
  assign cur_ph   = phase_r[v_r];
  assign cur_blen = PW'({blen_r[v_r], {FB{1'b0}}});
  assign cur_llen = PW'({llen_r[v_r], {FB{1'b0}}});

  // fetch address for body or loop
  always_comb begin
    if (mode_r[v_r] == fvm_pkg::MODE_BODY) begin
      rd_addr = AW'(bstart_r[v_r]) + AW'(cur_ph >> FB);
    end else begin
      rd_addr = AW'(lstart_r[v_r]) + AW'(cur_ph >> FB);
    end
  end

  // divider step: shift one dividend bit into the remainder
  logic [DW:0]   trial;
  logic          fits;
  logic [DW:0]   trial_sub;
  assign trial     = {rem_r, quo_r[PW-1]};
  assign fits      = (trial >= {1'b0, dvs_r});
  assign trial_sub = trial - {1'b0, dvs_r};

  // multiply-accumulate of one sample
  logic signed [15:0] prod;
  assign prod = rd_r * $signed({1'b0, vol_r[v_r]});

  // sub-step decision for the current voice
  logic sub_fetch;
  always_comb begin
    sub_fetch = 1'b0;
    case (mode_r[v_r])
      fvm_pkg::MODE_BODY: sub_fetch = (cur_ph < cur_blen);
      fvm_pkg::MODE_LOOP: sub_fetch = (llen_r[v_r] != '0) && (cur_ph < cur_llen);
      default:            sub_fetch = 1'b0;
    endcase
  end
  assign mem_re = (state_r == S_SUB) && sub_fetch;

  // sample memory write and registered read
  always_ff @(posedge clk) begin
    if (in_xfer && req == fvm_pkg::REQ_WRITE) begin
      mem[AW'(in_address)] <= in_sample_byte;
    end
    if (mem_re) begin
      rd_r <= $signed(mem[rd_addr]);
    end
  end

  // magnitude of a side sum
  logic [XW-1:0] mag_l, mag_r;
  assign mag_l = accl_r[XW-1] ? XW'(-accl_r) : XW'(accl_r);
  assign mag_r = accr_r[XW-1] ? XW'(-accr_r) : XW'(accr_r);

  logic [14:0] q15;
  assign q15 = neg_r ? 15'(-quo_r[14:0]) : quo_r[14:0];

  logic last_sub;
  assign last_sub = ({1'b0, s_r} + 5'd1 >= {1'b0, os_eff});

  // frame load into the output register
  logic out_load;
  assign out_load = (state_r == S_OUT) && (!out_valid_r || out_ready);

  // sequencer, voice state and output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      purp_r      <= P_STEP;
      os_cfg_r    <= fvm_pkg::OS_RESET;
      num_cfg_r   <= fvm_pkg::NUM_RESET;
      out_valid_r <= 1'b0;
      v_r         <= '0;
      s_r         <= '0;
      cnt_r       <= '0;
      for (int i = 0; i < NV; i++) begin
        mode_r[i]   <= fvm_pkg::MODE_SILENT;
        phase_r[i]  <= '0;
        step_r[i]   <= '0;
        vol_r[i]    <= '0;
        bstart_r[i] <= '0;
        blen_r[i]   <= '0;
        lstart_r[i] <= '0;
        llen_r[i]   <= '0;
      end
    end else begin
      if (cfg_we) begin
        if (fvm_pkg::cfg_idx_t'(cfg_index) == fvm_pkg::CFG_OVERSAMPLE) begin
          os_cfg_r <= cfg_wdata[3:0];
        end else begin
          num_cfg_r <= cfg_wdata;
        end
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && out_ready) begin
        out_valid_r <= 1'b0;
      end

      case (state_r)
        S_IDLE: begin
          if (in_xfer) begin
            case (req)
              fvm_pkg::REQ_NOTE, fvm_pkg::REQ_PERIOD: begin
                v_r <= in_voice;
                if (req == fvm_pkg::REQ_NOTE) begin
                  bstart_r[in_voice] <= in_address;
                  blen_r[in_voice]   <= in_body_length;
                  lstart_r[in_voice] <= in_loop_address;
                  llen_r[in_voice]   <= in_loop_length;
                  phase_r[in_voice]  <= '0;
                  mode_r[in_voice]   <= fvm_pkg::MODE_BODY;
                end
                if (in_period == '0) begin
                  step_r[in_voice] <= '0;
                end else begin
                  quo_r   <= PW'(num_cfg_r);
                  rem_r   <= '0;
                  dvs_r   <= DW'(in_period);
                  cnt_r   <= '0;
                  purp_r  <= P_STEP;
                  state_r <= S_DIV;
                end
              end
              fvm_pkg::REQ_VOLUME: begin
                vol_r[in_voice] <= (in_volume_request > fvm_pkg::MAX_VOL) ?
                                   fvm_pkg::MAX_VOL : in_volume_request;
              end
              fvm_pkg::REQ_TICK: begin
                v_r     <= '0;
                s_r     <= '0;
                accl_r  <= '0;
                accr_r  <= '0;
                state_r <= S_SUB;
              end
              default: begin
              end
            endcase
          end
        end

        S_SUB: begin
          if (sub_fetch) begin
            state_r <= S_MAC;
          end else if (mode_r[v_r] == fvm_pkg::MODE_BODY) begin
            // body done: move into the loop
            mode_r[v_r]  <= fvm_pkg::MODE_LOOP;
            phase_r[v_r] <= cur_ph - cur_blen;
          end else if (mode_r[v_r] == fvm_pkg::MODE_LOOP && llen_r[v_r] != '0) begin
            // wrap phase into the loop
            quo_r   <= cur_ph;
            rem_r   <= '0;
            dvs_r   <= DW'(cur_llen);
            cnt_r   <= '0;
            purp_r  <= P_MOD;
            state_r <= S_DIV;
          end else begin
            // silent or voice just ended: contributes zero
            mode_r[v_r] <= fvm_pkg::MODE_SILENT;
            if (!last_sub) begin
              s_r <= s_r + 4'd1;
            end else begin
              s_r <= '0;
              if (v_r == 2'(NV - 1)) begin
                state_r <= S_MIX;
              end else begin
                v_r <= v_r + 2'd1;
              end
            end
          end
        end

        S_MAC: begin
          if (v_r == 2'd0 || v_r == 2'd3) begin
            accl_r <= accl_r + XW'(prod);
          end else begin
            accr_r <= accr_r + XW'(prod);
          end
          phase_r[v_r] <= cur_ph + PW'(step_r[v_r]);
          if (!last_sub) begin
            s_r     <= s_r + 4'd1;
            state_r <= S_SUB;
          end else begin
            s_r <= '0;
            if (v_r == 2'(NV - 1)) begin
              state_r <= S_MIX;
            end else begin
              v_r     <= v_r + 2'd1;
              state_r <= S_SUB;
            end
          end
        end

        S_MIX: begin
          quo_r   <= PW'(mag_l);
          rem_r   <= '0;
          dvs_r   <= DW'(os_eff);
          neg_r   <= accl_r[XW-1];
          cnt_r   <= '0;
          purp_r  <= P_LEFT;
          state_r <= S_DIV;
        end

        S_DIV: begin
          if (cnt_r == CW'(PW)) begin
            case (purp_r)
              P_STEP: begin
                step_r[v_r] <= quo_r[31:0];
                state_r     <= S_IDLE;
              end
              P_MOD: begin
                phase_r[v_r] <= PW'(rem_r);
                state_r      <= S_SUB;
              end
              P_LEFT: begin
                left_r <= $signed(q15);
                quo_r  <= PW'(mag_r);
                rem_r  <= '0;
                neg_r  <= accr_r[XW-1];
                cnt_r  <= '0;
                purp_r <= P_RIGHT;
              end
              P_RIGHT: begin
                right_r <= $signed(q15);
                state_r <= S_OUT;
              end
              default: state_r <= S_IDLE;
            endcase
          end else begin
            rem_r <= fits ? DW'(trial_sub) : DW'(trial);
            quo_r <= {quo_r[PW-2:0], fits};
            cnt_r <= cnt_r + CW'(1);
          end
        end

        S_OUT: begin
          // hold the frame until the one ahead is transferred
          if (out_load) begin
            out_left_r  <= left_r;
            out_right_r <= right_r;
            state_r     <= S_IDLE;
          end
        end

        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_valid     = out_valid_r;
  assign out_left_mix  = out_left_r;
  assign out_right_mix = out_right_r;

  // unused-width guard on the span: loop length fits the divisor
  logic span_ok;
  assign span_ok = (SW <= DW);

  `FVM_ASSERT_NEXT(a_tick_busy, clk, rst_n, in_xfer && req == fvm_pkg::REQ_TICK, !in_ready, "tick transfer did not start the sequencer")
  `FVM_ASSERT_NOW(a_div_count, clk, rst_n, state_r == S_DIV, cnt_r <= CW'(PW) && span_ok, "divider count out of range")
  `FVM_ASSERT_NOW(a_vol_clamp, clk, rst_n, 1'b1, vol_r[v_r] <= fvm_pkg::MAX_VOL, "voice volume above clamp")
  `FVM_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid_r && !out_ready, out_valid_r && $stable(out_left_r) && $stable(out_right_r), "pending frame changed before transfer")

endmodule

### bench/four_voice_sample_playback_mixer_checker.sv
// ----------------------------------------------------------------------------
// four_voice_sample_playback_mixer_checker
// Watches the request, frame and register ports of the mixer. It keeps its
// own copy of the voices and the sample memory and predicts each stereo
// frame. It compares every frame transfer with the oldest predicted frame.
// ----------------------------------------------------------------------------
module four_voice_sample_playback_mixer_checker (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_we,
  input  logic               cfg_index,
  input  logic [31:0]        cfg_wdata,
  input  logic               in_valid,
  input  logic               in_ready,
  input  logic [2:0]         in_req_type,
  input  logic [1:0]         in_voice,
  input  logic [15:0]        in_address,
  input  logic signed [7:0]  in_sample_byte,
  input  logic [11:0]        in_period,
  input  logic [16:0]        in_body_length,
  input  logic [15:0]        in_loop_address,
  input  logic [16:0]        in_loop_length,
  input  logic [6:0]         in_volume_request,
  input  logic               out_valid,
  input  logic               out_ready,
  input  logic signed [14:0] out_left_mix,
  input  logic signed [14:0] out_right_mix,
  output int                 fails,
  output int                 pending
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [fvm_pkg::MIX_W-1:0] left;
    logic [fvm_pkg::MIX_W-1:0] right;
  } frame_t;

  // predicted voice state
  logic signed [7:0] wave_mem [0:(1<<fvm_pkg::SAMPLE_ADDR_BITS)-1];
  fvm_pkg::mode_t    v_mode      [fvm_pkg::VOICES];
  logic [63:0]       v_phase     [fvm_pkg::VOICES];
  logic [31:0]       v_step      [fvm_pkg::VOICES];
  logic [6:0]        v_vol       [fvm_pkg::VOICES];
  logic [15:0]       v_body_addr [fvm_pkg::VOICES];
  logic [16:0]       v_body_len  [fvm_pkg::VOICES];
  logic [15:0]       v_loop_addr [fvm_pkg::VOICES];
  logic [16:0]       v_loop_len  [fvm_pkg::VOICES];
  logic [3:0]        oversample_r;
  logic [31:0]       numerator_r;
  frame_t            frame_q [$];

  function automatic logic [31:0] step_for(logic [11:0] per);
    if (per == 12'd0) return 32'd0;
    return numerator_r / {20'd0, per};
  endfunction

  function automatic int scaled_sample(logic [15:0] base, logic [63:0] ph, int v);
    logic [15:0] a;
    a = base + ph[fvm_pkg::FRAC_BITS +: 16];
    return int'(wave_mem[a]) * int'(v_vol[v]);
  endfunction

  // one sub-step of one voice: body, then loop, else silence
  function automatic int voice_substep(int v);
    logic [63:0] span;
    int          val;
    if (v_mode[v] == fvm_pkg::MODE_BODY) begin
      span = 64'(v_body_len[v]) << fvm_pkg::FRAC_BITS;
      if (v_phase[v] < span) begin
        val = scaled_sample(v_body_addr[v], v_phase[v], v);
        v_phase[v] += 64'(v_step[v]);
        return val;
      end
      v_mode[v] = fvm_pkg::MODE_LOOP;
      v_phase[v] -= span;
    end
    if (v_mode[v] == fvm_pkg::MODE_LOOP) begin
      span = 64'(v_loop_len[v]) << fvm_pkg::FRAC_BITS;
      if (span == 64'd0) begin
        v_mode[v] = fvm_pkg::MODE_SILENT;
        return 0;
      end
      v_phase[v] = v_phase[v] % span;
      val = scaled_sample(v_loop_addr[v], v_phase[v], v);
      v_phase[v] += 64'(v_step[v]);
      return val;
    end
    v_mode[v] = fvm_pkg::MODE_SILENT;
    return 0;
  endfunction

  function automatic frame_t mix_frame();
    int     acc [fvm_pkg::VOICES];
    int     osn;
    int     l;
    int     r;
    frame_t f;
    osn = (oversample_r == 4'd0) ? 1 : int'(oversample_r);
    for (int c = 0; c < fvm_pkg::VOICES; c++) begin
      acc[c] = 0;
      for (int s = 0; s < osn; s++) acc[c] += voice_substep(c);
    end
    l = (acc[0] + acc[3]) / osn;
    r = (acc[1] + acc[2]) / osn;
    f.left  = l[fvm_pkg::MIX_W-1:0];
    f.right = r[fvm_pkg::MIX_W-1:0];
    return f;
  endfunction

  always @(posedge clk) begin
    frame_t f;
    if (!rst_n) begin
      for (int c = 0; c < fvm_pkg::VOICES; c++) begin
        v_mode[c]      = fvm_pkg::MODE_SILENT;
        v_phase[c]     = '0;
        v_step[c]      = '0;
        v_vol[c]       = '0;
        v_body_addr[c] = '0;
        v_body_len[c]  = '0;
        v_loop_addr[c] = '0;
        v_loop_len[c]  = '0;
      end
      oversample_r = fvm_pkg::OS_RESET;
      numerator_r  = fvm_pkg::NUM_RESET;
      frame_q.delete();
      fails = 0;
    end else begin
      // register writes
      if (cfg_we) begin
        if (cfg_index == fvm_pkg::CFG_OVERSAMPLE) oversample_r = cfg_wdata[3:0];
        else numerator_r = cfg_wdata;
      end
      // frame transfer
      if (out_valid && out_ready) begin
        if (frame_q.size() == 0) begin
          $display("%0t unexpected frame: expected none actual left %0d right %0d",
                   $time, out_left_mix, out_right_mix);
          fails++;
        end else begin
          f = frame_q.pop_front();
          if (f.left !== out_left_mix) begin
            $display("%0t left_mix mismatch: expected %0d actual %0d",
                     $time, $signed(f.left), out_left_mix);
            fails++;
          end
          if (f.right !== out_right_mix) begin
            $display("%0t right_mix mismatch: expected %0d actual %0d",
                     $time, $signed(f.right), out_right_mix);
            fails++;
          end
        end
      end
      // request transfer
      if (in_valid && in_ready) begin
        case (in_req_type)
          fvm_pkg::REQ_WRITE:  wave_mem[in_address] = in_sample_byte;
          fvm_pkg::REQ_NOTE: begin
            v_body_addr[in_voice] = in_address;
            v_body_len[in_voice]  = in_body_length;
            v_loop_addr[in_voice] = in_loop_address;
            v_loop_len[in_voice]  = in_loop_length;
            v_phase[in_voice]     = '0;
            v_mode[in_voice]      = fvm_pkg::MODE_BODY;
            v_step[in_voice]      = step_for(in_period);
          end
          fvm_pkg::REQ_PERIOD: v_step[in_voice] = step_for(in_period);
          fvm_pkg::REQ_VOLUME:
            v_vol[in_voice] = (in_volume_request > fvm_pkg::MAX_VOL) ?
                              fvm_pkg::MAX_VOL : in_volume_request;
          fvm_pkg::REQ_TICK:   frame_q.push_back(mix_frame());
          default: ;
        endcase
      end
    end
    pending = frame_q.size();
  end

endmodule

### bench/tb_four_voice_sample_playback_mixer.sv
// ----------------------------------------------------------------------------
// tb_four_voice_sample_playback_mixer
// Stimulus and verdict for the four-voice mixer. A directed set of notes,
// volumes and ticks is followed by random request streams under several
// register settings, with random stalls on both channels. Only sample bytes
// that were written are ever played; the checker judges every frame.
// ----------------------------------------------------------------------------
module tb_four_voice_sample_playback_mixer;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 20000000;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               cfg_we = 1'b0;
  logic               cfg_index = 1'b0;
  logic [31:0]        cfg_wdata = '0;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic [2:0]         in_req_type = '0;
  logic [1:0]         in_voice = '0;
  logic [15:0]        in_address = '0;
  logic signed [7:0]  in_sample_byte = '0;
  logic [11:0]        in_period = '0;
  logic [16:0]        in_body_length = '0;
  logic [15:0]        in_loop_address = '0;
  logic [16:0]        in_loop_length = '0;
  logic [6:0]         in_volume_request = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic signed [14:0] out_left_mix;
  logic signed [14:0] out_right_mix;
  int                 fails;
  int                 pending;

  bit                 written [0:(1<<fvm_pkg::SAMPLE_ADDR_BITS)-1];
  bit                 frozen [fvm_pkg::VOICES];
  bit                 no_idle = 1'b0;
  int                 out_stall = 0;
  int                 cycles = 0;
  int                 req_count = 0;
  int                 tick_count = 0;
  int                 setting_count = 0;

  four_voice_sample_playback_mixer i_dut (.*);

  four_voice_sample_playback_mixer_checker i_checker (.*);

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb_four_voice_sample_playback_mixer: FAIL");
      $finish;
    end
  end

  // frame channel backpressure in bursts
  always @(posedge clk) begin
    if (no_idle || !rst_n) begin
      out_ready <= rst_n;
    end else if (out_stall > 0) begin
      out_stall <= out_stall - 1;
      out_ready <= 1'b0;
    end else if ($urandom_range(0, 4) == 0) begin
      out_stall <= $urandom_range(1, 10) - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  // one request transfer; called at a rising edge, returns at the transfer edge or after a random idle gap
  task automatic send_req(fvm_pkg::req_t rt, logic [1:0] v, logic [15:0] addr,
                          logic [7:0] sb, logic [11:0] per, logic [16:0] blen,
                          logic [15:0] laddr, logic [16:0] llen, logic [6:0] vol);
    in_valid          <= 1'b1;
    in_req_type       <= rt;
    in_voice          <= v;
    in_address        <= addr;
    in_sample_byte    <= sb;
    in_period         <= per;
    in_body_length    <= blen;
    in_loop_address   <= laddr;
    in_loop_length    <= llen;
    in_volume_request <= vol;
    do @(negedge clk); while (!in_ready);
    @(posedge clk);
    req_count++;
    if (rt == fvm_pkg::REQ_TICK) tick_count++;
    if (!no_idle && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk);
    end
  endtask

  task automatic write_byte(logic [15:0] addr, logic [7:0] sb);
    send_req(fvm_pkg::REQ_WRITE, 2'($urandom), addr, sb, 12'($urandom), 17'($urandom),
             16'($urandom), 17'($urandom), 7'($urandom));
    written[addr] = 1'b1;
  endtask

  task automatic fill_span(logic [15:0] base, int len);
    logic [15:0] a;
    for (int i = 0; i < len; i++) begin
      a = base + 16'(i);
      if (!written[a]) write_byte(a, 8'($urandom));
    end
  endtask

  // long notes play with a zero step so only their first byte is read
  task automatic play_note(logic [1:0] v, logic [15:0] addr, logic [16:0] blen,
                           logic [15:0] laddr, logic [16:0] llen, logic [11:0] per);
    frozen[v] = (per == 12'd0);
    if (per == 12'd0) begin
      if (blen != 0) fill_span(addr, 1);
      else if (llen != 0) fill_span(laddr, 1);
    end else begin
      fill_span(addr, int'(blen));
      fill_span(laddr, int'(llen));
    end
    send_req(fvm_pkg::REQ_NOTE, v, addr, 8'($urandom), per, blen, laddr, llen,
             7'($urandom));
  endtask

  task automatic volume_req(logic [1:0] v, logic [6:0] vol);
    send_req(fvm_pkg::REQ_VOLUME, v, 16'($urandom), 8'($urandom), 12'($urandom),
             17'($urandom), 16'($urandom), 17'($urandom), vol);
  endtask

  task automatic set_period(logic [1:0] v, logic [11:0] per);
    send_req(fvm_pkg::REQ_PERIOD, v, 16'($urandom), 8'($urandom),
             frozen[v] ? 12'd0 : per,
             17'($urandom), 16'($urandom), 17'($urandom), 7'($urandom));
  endtask

  task automatic tick();
    send_req(fvm_pkg::REQ_TICK, 2'($urandom), 16'($urandom), 8'($urandom),
             12'($urandom), 17'($urandom), 16'($urandom), 17'($urandom),
             7'($urandom));
  endtask

  task automatic write_reg(fvm_pkg::cfg_idx_t idx, logic [31:0] val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  // drain all frames, then let a pending divide finish
  task automatic settle();
    in_valid <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (100) @(posedge clk);
  endtask

  task automatic random_requests(int count);
    int          r;
    int          sel;
    logic [1:0]  v;
    logic [16:0] blen;
    logic [16:0] llen;
    int          stop;
    stop = req_count + count;
    while (req_count < stop) begin
      r = $urandom_range(0, 99);
      v = 2'($urandom);
      if (r < 10) begin
        write_byte(16'($urandom), 8'($urandom));
      end else if (r < 25) begin
        if ($urandom_range(0, 9) == 0) begin
          blen = 17'($urandom_range(0, 65536));
          llen = 17'($urandom_range(0, 65536));
          play_note(v, 16'($urandom), blen, 16'($urandom), llen, 12'd0);
        end else begin
          blen = 17'($urandom_range(0, 32));
          llen = ($urandom_range(0, 3) == 0) ? 17'd0 : 17'($urandom_range(1, 32));
          sel  = $urandom_range(0, 3);
          play_note(v, 16'($urandom), blen, 16'($urandom), llen,
                    sel == 0 ? 12'($urandom) : 12'($urandom_range(0, 200)));
        end
      end else if (r < 35) begin
        set_period(v, 12'($urandom));
      end else if (r < 45) begin
        volume_req(v, 7'($urandom));
      end else if (r < 50) begin
        send_req(fvm_pkg::req_t'(3'($urandom_range(5, 7))), v, 16'($urandom),
                 8'($urandom), 12'($urandom), 17'($urandom), 16'($urandom),
                 17'($urandom), 7'($urandom));
      end else begin
        tick();
      end
    end
  endtask

  task automatic run_setting(logic [3:0] os, logic [31:0] num, int count);
    settle();
    write_reg(fvm_pkg::CFG_OVERSAMPLE, {28'd0, os});
    write_reg(fvm_pkg::CFG_NUMERATOR, num);
    setting_count++;
    @(posedge clk);
    random_requests(count);
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: extremes, clamp, wrap, immediate end, unknown requests
    write_reg(fvm_pkg::CFG_OVERSAMPLE, 32'd1);
    write_reg(fvm_pkg::CFG_NUMERATOR, 32'd329435);
    setting_count++;
    @(posedge clk);
    write_byte(16'h0000, 8'h80);
    write_byte(16'hFFFF, 8'h7F);
    write_byte(16'h0001, 8'h55);
    volume_req(2'd0, 7'd127);
    volume_req(2'd1, 7'd64);
    volume_req(2'd2, 7'd65);
    volume_req(2'd3, 7'd0);
    play_note(2'd0, 16'hFFFF, 17'd2, 16'h0000, 17'd0, 12'd1);
    play_note(2'd1, 16'h0001, 17'd0, 16'h0000, 17'd0, 12'd4095);
    play_note(2'd2, 16'h0001, 17'd65536, 16'hFFFF, 17'd65536, 12'd0);
    play_note(2'd3, 16'h0000, 17'd1, 16'hFFFF, 17'd2, 12'd4095);
    tick();
    volume_req(2'd3, 7'd64);
    set_period(2'd0, 12'd4095);
    tick();
    send_req(fvm_pkg::req_t'(3'd5), 2'd0, '0, '0, '0, '0, '0, '0, '0);
    send_req(fvm_pkg::req_t'(3'd6), 2'd1, '1, '1, '1, '1, '1, '1, '1);
    send_req(fvm_pkg::req_t'(3'd7), 2'd2, '0, '0, '0, '0, '0, '0, '0);
    tick();
    tick();

    // random phases across register settings
    run_setting(4'd8, 32'hFFFF_FFFF, 400);
    run_setting(4'd0, 32'd0, 300);
    run_setting(4'd15, $urandom, 250);
    run_setting(4'd2, $urandom_range(0, 1 << 22), 400);
    run_setting(4'd4, 32'd329435, 300);
    no_idle = 1'b1;
    random_requests(180);

    in_valid <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (300) @(posedge clk);
    $display("Covered %0d requests, %0d of them ticks, over %0d register settings",
             req_count, tick_count, setting_count);
    $display("with notes, loops, period and volume changes and stalls on both sides");
    if (fails == 0) begin
      $display("tb_four_voice_sample_playback_mixer: PASS");
    end else begin
      $display("tb_four_voice_sample_playback_mixer: FAIL");
    end
    $finish;
  end

endmodule
